@@ hw/rtl/pcmrms_pkg.sv @@
// shared widths and constants for the pcm converter and level meter
`timescale 1ns / 1ps
`default_nettype none

package pcmrms_pkg;

  localparam int RAW_W  = 32;  // i2s word
  localparam int SHIFT  = 14;  // arithmetic shift applied to each word
  localparam int PCM_W  = 16;  // pcm sample
  localparam int MAG_W  = 16;  // |sample|, holds 32768
  localparam int PEAK_W = 15;
  localparam int RMS_W  = 16;
  localparam int LEN_W  = 11;
  localparam int NUM_W  = 32;
  localparam int SQ_W   = 32;  // radicand window of the root unit
  localparam int REM_W  = 18;  // partial remainder of the root unit

  localparam logic [PCM_W-1:0]  PCM_MAX  = 16'h7fff;
  localparam logic [PCM_W-1:0]  PCM_MIN  = 16'h8000;
  localparam logic [PEAK_W-1:0] PEAK_MAX = 15'h7fff;

endpackage

`default_nettype wire

@@ hw/rtl/pcmrms_in_if.sv @@
// input channel: one i2s word per item
`timescale 1ns / 1ps
`default_nettype none

interface pcmrms_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcmrms_pkg::RAW_W-1:0] raw_word;
  logic                                last;

  modport source (output valid, raw_word, last, input ready);
  modport sink   (input valid, raw_word, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pcmrms_out_if.sv @@
// result channel: pcm sample plus chunk statistics per item
`timescale 1ns / 1ps
`default_nettype none

interface pcmrms_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcmrms_pkg::PCM_W-1:0] pcm_sample;
  logic                                chunk_done;
  logic        [pcmrms_pkg::RMS_W-1:0] rms_level;
  logic        [pcmrms_pkg::PEAK_W-1:0] peak_level;
  logic        [pcmrms_pkg::LEN_W-1:0] chunk_length;
  logic        [pcmrms_pkg::NUM_W-1:0] chunk_number;

  modport source (output valid, pcm_sample, chunk_done, rms_level, peak_level,
                  chunk_length, chunk_number, input ready);
  modport sink   (input valid, pcm_sample, chunk_done, rms_level, peak_level,
                  chunk_length, chunk_number, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/pcmrms_divsqrt.sv @@
// serial divider followed by a restoring bit-by-bit square root
`timescale 1ns / 1ps
`default_nettype none

module pcmrms_divsqrt #(
  parameter int SUM_W = 41,
  parameter int CNT_W = 11
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [SUM_W-1:0]              dividend,
  input  wire logic [CNT_W-1:0]              divisor,
  output logic                               done,
  output logic [pcmrms_pkg::RMS_W-1:0]       root
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam int SQ_W   = pcmrms_pkg::SQ_W;
  localparam int REM_W  = pcmrms_pkg::REM_W;
  localparam int RT_W   = pcmrms_pkg::RMS_W;
  localparam int ROOT_STEPS = SQ_W / 2;

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_DIV  = 3'b010,
    DS_ROOT = 3'b100
  } ds_state_t;

  ds_state_t          state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SUM_W-1:0]   dvd_r, dvd_nxt;
  logic [CNT_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W:0]     drem_r, drem_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [REM_W-1:0]   srem_r, srem_nxt;
  logic [RT_W-1:0]    root_r, root_nxt;
  logic               done_r, done_nxt;

  logic [CNT_W:0]       drem_sh;
  logic                 dge;
  logic [SUM_W-1:0]     dvd_shift;
  logic [SUM_W+SQ_W-1:0] q_ext;
  logic [REM_W+1:0]     srem_sh;
  logic [REM_W+1:0]     trial;
  logic [REM_W+1:0]     srem_diff;
  logic                 sge;

  // one quotient bit per cycle
  assign drem_sh   = {drem_r[CNT_W-1:0], dvd_r[SUM_W-1]};
  assign dge       = drem_sh >= {1'b0, dvs_r};
  assign dvd_shift = {dvd_r[SUM_W-2:0], dge};
  assign q_ext     = {{SQ_W{1'b0}}, dvd_shift};

  // one root bit per cycle, two radicand bits in
  assign srem_sh   = {srem_r, sq_r[SQ_W-1:SQ_W-2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign sge       = srem_sh >= trial;
  assign srem_diff = srem_sh - trial;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    drem_nxt  = drem_r;
    sq_nxt    = sq_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DS_IDLE: begin
        if (start) begin
          dvd_nxt   = dividend;
          dvs_nxt   = divisor;
          drem_nxt  = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = DS_DIV;
        end
      end
      DS_DIV: begin
        drem_nxt = dge ? (drem_sh - {1'b0, dvs_r}) : drem_sh;
        dvd_nxt  = dvd_shift;
        if (step_r == '0) begin
          // quotient never exceeds 2^30, so the low window holds it all
          sq_nxt    = q_ext[SQ_W-1:0];
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(ROOT_STEPS - 1);
          state_nxt = DS_ROOT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      DS_ROOT: begin
        srem_nxt = sge ? srem_diff[REM_W-1:0] : srem_sh[REM_W-1:0];
        root_nxt = {root_r[RT_W-2:0], sge};
        sq_nxt   = {sq_r[SQ_W-3:0], 2'b00};
        if (step_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = DS_IDLE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      default: state_nxt = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    drem_r <= drem_nxt;
    sq_r   <= sq_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

@@ hw/rtl/pcm_convert_rms_peak_meter_top.sv @@
// pcm conversion with chunk rms and peak metering, top level
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  raw_word[31:0] signed, last
//   out_ch   out  valid/ready  pcm_sample, chunk_done, rms_level, peak_level,
//                              chunk_length, chunk_number
//
// one item at a time: each is taken and squared bit-serially, one shift-and-add
// step per significant bit of |sample| (up to 16); a closing item also runs the
// divider (31+clog2(MAX_SAMPLES) quotient bits) and the 16-bit root before emit
// the output register holds a result while the next item is taken and squared
// synchronous active-low reset clears accumulators, chunk counter and valids
`timescale 1ns / 1ps
`default_nettype none

module pcm_convert_rms_peak_meter_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  pcmrms_in_if.sink     in_ch,
  pcmrms_out_if.source  out_ch
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = 31 + $clog2(MAX_SAMPLES);
  localparam int RAW_W  = pcmrms_pkg::RAW_W;
  localparam int SH_W   = pcmrms_pkg::RAW_W - pcmrms_pkg::SHIFT;
  localparam int PCM_W  = pcmrms_pkg::PCM_W;
  localparam int MAG_W  = pcmrms_pkg::MAG_W;
  localparam int PEAK_W = pcmrms_pkg::PEAK_W;
  localparam int RMS_W  = pcmrms_pkg::RMS_W;
  localparam int LEN_W  = pcmrms_pkg::LEN_W;
  localparam int NUM_W  = pcmrms_pkg::NUM_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DSQ  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]   mcand_r, mcand_nxt;
  logic [MAG_W-1:0]   mplier_r, mplier_nxt;
  logic [PEAK_W-1:0]  peak_r, peak_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [NUM_W-1:0]   counter_r, counter_nxt;
  logic [PCM_W-1:0]   pcm_r, pcm_nxt;
  logic               close_r, close_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PCM_W-1:0]   out_pcm_r, out_pcm_nxt;
  logic               out_done_r, out_done_nxt;
  logic [RMS_W-1:0]   out_rms_r, out_rms_nxt;
  logic [PEAK_W-1:0]  out_peak_r, out_peak_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [NUM_W-1:0]   out_num_r, out_num_nxt;

  logic [SH_W-1:0]        shifted;
  logic                   in_range;
  logic [PCM_W-1:0]       sample;
  logic [MAG_W-1:0]       mag;
  logic [PEAK_W-1:0]      mag_sat;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W+LEN_W-1:0] len_ext;
  logic                   dsq_start;
  logic                   dsq_done;
  logic [RMS_W-1:0]       dsq_root;

  // word >>> 14, then clamp to 16 bits
  assign shifted  = in_ch.raw_word[RAW_W-1:pcmrms_pkg::SHIFT];
  assign in_range = (&shifted[SH_W-1:PCM_W-1]) || !(|shifted[SH_W-1:PCM_W-1]);

  always_comb begin
    priority if (in_range) begin
      sample = shifted[PCM_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sample = pcmrms_pkg::PCM_MIN;
    end else begin
      sample = pcmrms_pkg::PCM_MAX;
    end
  end

  assign mag     = sample[PCM_W-1] ? (~sample + 1'b1) : sample;
  assign mag_sat = mag[MAG_W-1] ? pcmrms_pkg::PEAK_MAX : mag[PEAK_W-1:0];
  assign cnt_inc = count_r + 1'b1;
  assign len_ext = {{LEN_W{1'b0}}, count_r};

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    peak_nxt      = peak_r;
    count_nxt     = count_r;
    counter_nxt   = counter_r;
    pcm_nxt       = pcm_r;
    close_nxt     = close_r;
    out_valid_nxt = out_valid_r;
    out_pcm_nxt   = out_pcm_r;
    out_done_nxt  = out_done_r;
    out_rms_nxt   = out_rms_r;
    out_peak_nxt  = out_peak_r;
    out_len_nxt   = out_len_r;
    out_num_nxt   = out_num_r;
    dsq_start     = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          pcm_nxt    = sample;
          mcand_nxt  = SUM_W'(mag);
          mplier_nxt = mag;
          if (mag_sat > peak_r) begin
            peak_nxt = mag_sat;
          end
          count_nxt  = cnt_inc;
          close_nxt  = in_ch.last || (cnt_inc >= CNT_W'(MAX_SAMPLES));
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        // shift-and-add square straight into the running sum
        if (mplier_r == '0) begin
          if (close_r) begin
            dsq_start = 1'b1;
            state_nxt = ST_DSQ;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          if (mplier_r[0]) begin
            sum_nxt = sum_r + mcand_r;
          end
          mcand_nxt  = {mcand_r[SUM_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[MAG_W-1:1]};
        end
      end
      ST_DSQ: begin
        if (dsq_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_pcm_nxt   = pcm_r;
          out_done_nxt  = close_r;
          if (close_r) begin
            out_rms_nxt  = dsq_root;
            out_peak_nxt = peak_r;
            out_len_nxt  = len_ext[LEN_W-1:0];
            out_num_nxt  = counter_r + 1'b1;
            counter_nxt  = counter_r + 1'b1;
            sum_nxt      = '0;
            peak_nxt     = '0;
            count_nxt    = '0;
          end else begin
            out_rms_nxt  = '0;
            out_peak_nxt = '0;
            out_len_nxt  = '0;
            out_num_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      counter_r   <= counter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    pcm_r      <= pcm_nxt;
    close_r    <= close_nxt;
    out_pcm_r  <= out_pcm_nxt;
    out_done_r <= out_done_nxt;
    out_rms_r  <= out_rms_nxt;
    out_peak_r <= out_peak_nxt;
    out_len_r  <= out_len_nxt;
    out_num_r  <= out_num_nxt;
  end

  pcmrms_divsqrt #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dsq_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (dsq_done),
    .root     (dsq_root)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pcm_sample   = out_pcm_r;
  assign out_ch.chunk_done   = out_done_r;
  assign out_ch.rms_level    = out_rms_r;
  assign out_ch.peak_level   = out_peak_r;
  assign out_ch.chunk_length = out_len_r;
  assign out_ch.chunk_number = out_num_r;

endmodule

`default_nettype wire
